/* sv/hrpf_pkg.sv */
// ----------------------------------------------------------------------------
// hrpf_pkg
// Shared types, byte positions, verdict codes and offset helpers of the
// HTTP request frame filter.
// ----------------------------------------------------------------------------
package hrpf_pkg;

   localparam int unsigned HeadDepth = 6;

   localparam logic [15:0] PosTypeHi = 16'd12;
   localparam logic [15:0] PosTypeLo = 16'd13;
   localparam logic [15:0] PosIhl    = 16'd14;
   localparam logic [15:0] PosLenHi  = 16'd16;
   localparam logic [15:0] PosLenLo  = 16'd17;
   localparam logic [15:0] PosProto  = 16'd23;
   localparam logic [15:0] PosMax    = 16'hFFFF;

   localparam logic [7:0]  EthHeaderBytes = 8'd14;
   localparam logic [6:0]  DoffBase       = 7'd26;
   localparam logic [15:0] EtherTypeIpv4  = 16'h0800;
   localparam logic [7:0]  ProtoTcp       = 8'd6;
   localparam logic [3:0]  MinTcpWords    = 4'd3;
   localparam logic signed [17:0] MinPayload = 18'sd7;

   localparam logic [7:0] ChH = 8'h48;
   localparam logic [7:0] ChT = 8'h54;
   localparam logic [7:0] ChP = 8'h50;
   localparam logic [7:0] ChG = 8'h47;
   localparam logic [7:0] ChE = 8'h45;
   localparam logic [7:0] ChO = 8'h4F;
   localparam logic [7:0] ChS = 8'h53;
   localparam logic [7:0] ChU = 8'h55;
   localparam logic [7:0] ChD = 8'h44;
   localparam logic [7:0] ChL = 8'h4C;
   localparam logic [7:0] ChA = 8'h41;

   localparam logic [2:0] MethodNone   = 3'd0;
   localparam logic [2:0] MethodHttp   = 3'd1;
   localparam logic [2:0] MethodGet    = 3'd2;
   localparam logic [2:0] MethodPost   = 3'd3;
   localparam logic [2:0] MethodPut    = 3'd4;
   localparam logic [2:0] MethodDelete = 3'd5;
   localparam logic [2:0] MethodHead   = 3'd6;

   localparam logic [2:0] CauseKept     = 3'd0;
   localparam logic [2:0] CauseNotIpv4  = 3'd1;
   localparam logic [2:0] CauseNotTcp   = 3'd2;
   localparam logic [2:0] CauseShortPay = 3'd3;
   localparam logic [2:0] CauseNoMatch  = 3'd4;
   localparam logic [2:0] CauseTooShort = 3'd5;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic       keep;
      logic [2:0] method_kind;
      logic [2:0] drop_cause;
   } rsp_type;

   typedef struct packed {
      logic [15:0]                 pos;
      logic [15:0]                 ether_type;
      logic [7:0]                  ip_protocol;
      logic [3:0]                  ip_header_words;
      logic [15:0]                 ip_total_length;
      logic [3:0]                  tcp_header_words;
      logic [HeadDepth-1:0][7:0]   payload_head;
   } fields_type;

   function automatic logic [6:0] doff_pos_f(input logic [3:0] ihl);
      doff_pos_f = DoffBase + {1'b0, ihl, 2'b00};
   endfunction

   function automatic logic [7:0] pay_off_f(input logic [3:0] ihl, input logic [3:0] tcp);
      pay_off_f = EthHeaderBytes + {2'b00, ihl, 2'b00} + {2'b00, tcp, 2'b00};
   endfunction

endpackage

/* sv/hrpf_capture.sv */
// ----------------------------------------------------------------------------
// hrpf_capture
// Byte position counter and header field capture; presents the fields as
// they stand after the current byte.
// ----------------------------------------------------------------------------
module hrpf_capture (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           frame_byte,
   input  logic                 end_of_frame,
   output hrpf_pkg::fields_type fields
);
   import hrpf_pkg::*;

   fields_type state_ff;
   fields_type state_in;
   fields_type upd;
   logic [6:0]  doff_pos;
   logic [7:0]  pay_off;
   logic [15:0] rel;
   logic        cap;

   always_comb begin
      upd = state_ff;
      if (state_ff.pos == PosTypeHi) upd.ether_type[15:8] = frame_byte;
      if (state_ff.pos == PosTypeLo) upd.ether_type[7:0] = frame_byte;
      if (state_ff.pos == PosIhl) upd.ip_header_words = frame_byte[3:0];
      if (state_ff.pos == PosLenHi) upd.ip_total_length[15:8] = frame_byte;
      if (state_ff.pos == PosLenLo) upd.ip_total_length[7:0] = frame_byte;
      if (state_ff.pos == PosProto) upd.ip_protocol = frame_byte;
      doff_pos = doff_pos_f(upd.ip_header_words);
      if (state_ff.pos == 16'(doff_pos)) upd.tcp_header_words = frame_byte[7:4];
      pay_off = pay_off_f(upd.ip_header_words, upd.tcp_header_words);
      rel = state_ff.pos - 16'(pay_off);
      cap = (state_ff.pos >= 16'(doff_pos)) && (upd.tcp_header_words >= MinTcpWords) &&
            (state_ff.pos >= 16'(pay_off)) &&
            (state_ff.pos < 16'(pay_off) + 16'(HeadDepth));
      if (cap) upd.payload_head[rel[2:0]] = frame_byte;
   end

   always_comb begin
      state_in = upd;
      if (state_ff.pos != PosMax) state_in.pos = state_ff.pos + 16'd1;
      if (end_of_frame) state_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign fields = upd;

endmodule

/* sv/hrpf_verdict.sv */
// ----------------------------------------------------------------------------
// hrpf_verdict
// Frame checks in priority order and HTTP method match on the payload head.
// ----------------------------------------------------------------------------
module hrpf_verdict (
   input  hrpf_pkg::fields_type fields,
   output hrpf_pkg::rsp_type    verdict
);
   import hrpf_pkg::*;

   logic [6:0]         doff_pos;
   logic [7:0]         pay_off;
   logic signed [17:0] plen;
   logic [2:0]         kind;
   logic [HeadDepth-1:0][7:0] h;

   assign h = fields.payload_head;

   always_comb begin
      kind = MethodNone;
      if (h[0] == ChH && h[1] == ChT && h[2] == ChT && h[3] == ChP) begin
         kind = MethodHttp;
      end else if (h[0] == ChG && h[1] == ChE && h[2] == ChT) begin
         kind = MethodGet;
      end else if (h[0] == ChP && h[1] == ChO && h[2] == ChS && h[3] == ChT) begin
         kind = MethodPost;
      end else if (h[0] == ChP && h[1] == ChU && h[2] == ChT) begin
         kind = MethodPut;
      end else if (h[0] == ChD && h[1] == ChE && h[2] == ChL && h[3] == ChE &&
                   h[4] == ChT && h[5] == ChE) begin
         kind = MethodDelete;
      end else if (h[0] == ChH && h[1] == ChE && h[2] == ChA && h[3] == ChD) begin
         kind = MethodHead;
      end
   end

   always_comb begin
      doff_pos = doff_pos_f(fields.ip_header_words);
      pay_off  = pay_off_f(fields.ip_header_words, fields.tcp_header_words);
      plen = $signed({2'b00, fields.ip_total_length}) -
             $signed({12'd0, fields.ip_header_words, 2'b00}) -
             $signed({12'd0, fields.tcp_header_words, 2'b00});
      verdict = '{keep: 1'b0, method_kind: MethodNone, drop_cause: CauseKept};
      if (fields.pos < PosTypeLo) begin
         verdict.drop_cause = CauseTooShort;
      end else if (fields.ether_type != EtherTypeIpv4) begin
         verdict.drop_cause = CauseNotIpv4;
      end else if (fields.pos < PosProto) begin
         verdict.drop_cause = CauseTooShort;
      end else if (fields.ip_protocol != ProtoTcp) begin
         verdict.drop_cause = CauseNotTcp;
      end else if (fields.pos < 16'(doff_pos)) begin
         verdict.drop_cause = CauseTooShort;
      end else if (plen < MinPayload || fields.tcp_header_words < MinTcpWords) begin
         verdict.drop_cause = CauseShortPay;
      end else if (fields.pos < 16'(pay_off) + 16'(HeadDepth - 1)) begin
         verdict.drop_cause = CauseTooShort;
      end else if (kind != MethodNone) begin
         verdict.keep        = 1'b1;
         verdict.method_kind = kind;
      end else begin
         verdict.drop_cause = CauseNoMatch;
      end
   end

endmodule

/* sv/http_request_packet_filter.sv */
// ----------------------------------------------------------------------------
// http_request_packet_filter
// Ethernet/IPv4/TCP frame filter that keeps frames whose payload opens with
// an HTTP method and drops the rest with a cause code.
// ----------------------------------------------------------------------------
//  channel  direction  payload   transfer
//  req_     in         req_type  one frame byte per request, end mark on last
//  rsp_     out        rsp_type  one verdict per frame, after the last byte
//
//  Takes one byte every cycle but while a last byte waits; a verdict is
//  valid the cycle after its last byte advances. The input register and the
//  result register each hold one entry. A last byte waits in the input
//  register only while an older verdict is still untaken; other bytes never
//  wait on rsp_ready. Reset clears all captured fields and both valid flags.
// ----------------------------------------------------------------------------
module http_request_packet_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hrpf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hrpf_pkg::rsp_type rsp_data
);
   import hrpf_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   rsp_type    out_data_ff;
   logic       advance;
   fields_type fields;
   rsp_type    verdict;

   assign advance   = in_valid_ff && (!in_eof_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_eof_ff) || (out_valid_ff && !rsp_ready);

   hrpf_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .frame_byte   (in_byte_ff),
      .end_of_frame (in_eof_ff),
      .fields       (fields)
   );

   hrpf_verdict u_verdict (
      .fields  (fields),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data.frame_byte;
         in_eof_ff  <= req_data.end_of_frame;
      end
      if (advance && in_eof_ff) begin
         out_data_ff <= verdict;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTH
   a_keep_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.keep |->
         rsp_data.method_kind != MethodNone && rsp_data.drop_cause == CauseKept)
      else $error("kept frame without method or with cause");

   a_drop_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.keep |->
         rsp_data.method_kind == MethodNone && rsp_data.drop_cause != CauseKept)
      else $error("dropped frame with method or without cause");

   a_last_to_rsp : assert property (@(posedge clock) disable iff (reset)
      advance && in_eof_ff |=> rsp_valid)
      else $error("verdict lost");

   a_hold_last : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_eof_ff && rsp_valid && !rsp_ready |->
         !req_ready && !advance)
      else $error("last byte advanced over untaken verdict");

   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eof_ff))
      else $error("stalled input register changed");
`endif

endmodule

/* test/tb_http_request_packet_filter.sv */
// ----------------------------------------------------------------------------
// tb_http_request_packet_filter
// Streams Ethernet frames into the HTTP request filter one byte per request
// and checks every keep/drop verdict against a byte-level model of the
// header capture. Directed frames hit each method and drop cause, then
// random frames mix well-formed TCP traffic with corrupted and noise frames
// under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_http_request_packet_filter;
   import hrpf_pkg::*;

   localparam int RandomBytes     = 150;
   localparam int CycleLimit      = 4_000_000;

   class frame_verdicts;
      logic [15:0] position;
      logic [15:0] ether_type;
      logic [7:0]  ip_proto;
      logic [3:0]  ihl;
      logic [15:0] total_length;
      logic [3:0]  tcp_words;
      logic [7:0]  head [HeadDepth];
      rsp_type     pending [$];
      int          mismatches;

      function new();
         position     = '0;
         ether_type   = '0;
         ip_proto     = '0;
         ihl          = '0;
         total_length = '0;
         tcp_words    = '0;
         foreach (head[i]) head[i] = '0;
         mismatches   = 0;
      endfunction

      function bit head_starts(string pat);
         for (int i = 0; i < pat.len(); i++) begin
            if (head[i] != pat[i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_byte(req_type r);
         int      p;
         int      ipb;
         int      doffp;
         int      payoff;
         int      plen;
         rsp_type v;
         p     = int'(position);
         ipb   = 4 * int'(ihl);
         doffp = int'(DoffBase) + ipb;
         if (p == PosTypeHi) ether_type[15:8] = r.frame_byte;
         if (p == PosTypeLo) ether_type[7:0] = r.frame_byte;
         if (p == PosIhl) begin
            ihl   = r.frame_byte[3:0];
            ipb   = 4 * int'(ihl);
            doffp = int'(DoffBase) + ipb;
         end
         if (p == PosLenHi) total_length[15:8] = r.frame_byte;
         if (p == PosLenLo) total_length[7:0] = r.frame_byte;
         if (p == PosProto) ip_proto = r.frame_byte;
         if (p == doffp) tcp_words = r.frame_byte[7:4];
         payoff = int'(EthHeaderBytes) + ipb + 4 * int'(tcp_words);
         if (p >= doffp && tcp_words >= MinTcpWords && p >= payoff &&
             p < payoff + int'(HeadDepth))
            head[p - payoff] = r.frame_byte;
         if (position != PosMax) position++;
         if (!r.end_of_frame) return;

         v = '0;
         if (p < PosTypeLo) begin
            v.drop_cause = CauseTooShort;
         end else if (ether_type != EtherTypeIpv4) begin
            v.drop_cause = CauseNotIpv4;
         end else if (p < PosProto) begin
            v.drop_cause = CauseTooShort;
         end else if (ip_proto != ProtoTcp) begin
            v.drop_cause = CauseNotTcp;
         end else if (p < doffp) begin
            v.drop_cause = CauseTooShort;
         end else begin
            plen = int'(total_length) - ipb - 4 * int'(tcp_words);
            if (plen < int'(MinPayload) || tcp_words < MinTcpWords) begin
               v.drop_cause = CauseShortPay;
            end else if (p < payoff + int'(HeadDepth) - 1) begin
               v.drop_cause = CauseTooShort;
            end else begin
               if (head_starts("HTTP")) v.method_kind = MethodHttp;
               else if (head_starts("GET")) v.method_kind = MethodGet;
               else if (head_starts("POST")) v.method_kind = MethodPost;
               else if (head_starts("PUT")) v.method_kind = MethodPut;
               else if (head_starts("DELETE")) v.method_kind = MethodDelete;
               else if (head_starts("HEAD")) v.method_kind = MethodHead;
               if (v.method_kind == MethodNone) v.drop_cause = CauseNoMatch;
               else v.keep = 1'b1;
            end
         end
         pending.push_back(v);

         position     = '0;
         ether_type   = '0;
         ip_proto     = '0;
         ihl          = '0;
         total_length = '0;
         tcp_words    = '0;
         foreach (head[i]) head[i] = '0;
      endfunction

      function void check_verdict(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected verdict, expected none, actual %h", $time, got);
            return;
         end
         want = pending.pop_front();
         if (got.keep != want.keep) begin
            mismatches++;
            $display("%0t: keep expected %0d actual %0d", $time, want.keep, got.keep);
         end
         if (got.method_kind != want.method_kind) begin
            mismatches++;
            $display("%0t: method_kind expected %0d actual %0d", $time,
                     want.method_kind, got.method_kind);
         end
         if (got.drop_cause != want.drop_cause) begin
            mismatches++;
            $display("%0t: drop_cause expected %0d actual %0d", $time,
                     want.drop_cause, got.drop_cause);
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   frame_verdicts verdicts = new();
   logic [7:0]    frame_bytes [$];
   string         words [13] = '{"HTTP", "GET", "POST", "PUT", "DELETE", "HEAD", "HTTX",
                                 "GEX", "POSX", "PUX", "DELETX", "HEAP", "get "};
   bit            calm = 1'b0;
   int            stall_left = 0;
   int            cycles = 0;
   int            bytes_sent = 0;

   http_request_packet_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) verdicts.check_verdict(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= (stall_left == 0);
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      verdicts.note_byte(r);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_request(req_type'{frame_byte: frame_bytes[i],
                                end_of_frame: (i == frame_bytes.size() - 1)});
      bytes_sent += frame_bytes.size();
   endtask

   function automatic void make_frame(int ihl, int doff, int plen, string text, int tot,
                                      int flen);
      int payoff;
      int doffp;
      int full;
      payoff = int'(EthHeaderBytes) + 4 * ihl + 4 * doff;
      doffp  = int'(DoffBase) + 4 * ihl;
      full   = payoff + plen;
      if (full < doffp + 1) full = doffp + 1;
      if (tot < 0) tot = 4 * ihl + 4 * doff + plen;
      frame_bytes.delete();
      repeat (full) frame_bytes.push_back(8'($urandom));
      frame_bytes[PosTypeHi] = EtherTypeIpv4[15:8];
      frame_bytes[PosTypeLo] = EtherTypeIpv4[7:0];
      frame_bytes[PosIhl]    = {4'h4, 4'(ihl)};
      frame_bytes[PosLenHi]  = 8'(tot >> 8);
      frame_bytes[PosLenLo]  = 8'(tot);
      frame_bytes[PosProto]  = ProtoTcp;
      frame_bytes[doffp]     = {4'(doff), frame_bytes[doffp][3:0]};
      for (int i = 0; i < text.len() && payoff + i < full; i++)
         frame_bytes[payoff + i] = text[i];
      if (flen > 0) begin
         while (frame_bytes.size() > flen) void'(frame_bytes.pop_back());
         while (frame_bytes.size() < flen) frame_bytes.push_back(8'($urandom));
      end
   endfunction

   function automatic void make_random_frame();
      int kind;
      int ihl;
      int doff;
      int plen;
      int tot;
      kind = $urandom_range(0, 99);
      if (kind >= 85) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 60)) frame_bytes.push_back(8'($urandom));
         return;
      end
      ihl = 5;
      if ($urandom_range(0, 3) == 0) ihl = $urandom_range(0, 15);
      doff = 5;
      if ($urandom_range(0, 3) == 0) doff = $urandom_range(0, 15);
      plen = $urandom_range(7, 24);
      if ($urandom_range(0, 7) == 0) plen = $urandom_range(0, 6);
      tot = -1;
      if ($urandom_range(0, 9) == 0) tot = $urandom_range(0, 65535);
      make_frame(ihl, doff, plen, words[$urandom_range(0, 12)], tot, 0);
      if (kind >= 70) begin
         case ($urandom_range(0, 2))
            0: frame_bytes[PosTypeHi + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            1: frame_bytes[PosProto] = 8'($urandom);
            default: begin
               repeat ($urandom_range(1, frame_bytes.size() - 1))
                  void'(frame_bytes.pop_back());
            end
         endcase
      end else if (kind >= 60) begin
         repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
      end
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      make_frame(5, 5, 8, "GET /", -1, 0);    send_frame();
      make_frame(5, 5, 8, "POST", -1, 0);     send_frame();
      make_frame(5, 5, 8, "PUT", -1, 0);      send_frame();
      make_frame(5, 5, 8, "DELETE", -1, 0);   send_frame();
      make_frame(5, 5, 7, "HEAD", -1, 0);     send_frame();
      make_frame(15, 15, 8, "HTTP/1.1", -1, 0); send_frame();
      make_frame(5, 5, 8, "FOO", -1, 0);      send_frame();
      make_frame(5, 5, 8, "GET", -1, 0);
      frame_bytes[PosTypeHi] = 8'h86;
      frame_bytes[PosTypeLo] = 8'hDD;
      send_frame();
      make_frame(5, 5, 8, "GET", -1, 0);
      frame_bytes[PosProto] = 8'd17;
      send_frame();
      make_frame(5, 5, 6, "GET", -1, 0);      send_frame();
      make_frame(5, 5, 8, "GET", 10, 0);      send_frame();
      make_frame(5, 2, 8, "GET", -1, 0);      send_frame();
      make_frame(5, 5, 20, "GET", -1, 57);    send_frame();
      make_frame(2, 5, 8, "HEAD", -1, 0);     send_frame();
      make_frame(0, 15, 8, "PUT", -1, 0);     send_frame();
      make_frame(5, 5, 20, "GET", -1, 13);    send_frame();
      make_frame(5, 5, 20, "GET", -1, 20);    send_frame();
      make_frame(5, 5, 20, "GET", -1, 40);    send_frame();
      frame_bytes = '{8'hFF};
      send_frame();
      frame_bytes.delete();
      repeat (30) frame_bytes.push_back(8'h00);
      send_frame();
      make_frame(5, 5, 20, "GET", -1, 150);   send_frame();

      bytes_sent = 0;
      while (bytes_sent < RandomBytes) begin
         make_random_frame();
         send_frame();
      end

      calm = 1'b1;
      repeat (2) begin
         make_random_frame();
         send_frame();
      end
      req_valid <= 1'b0;

      while (verdicts.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (verdicts.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

/* sim.f */
sv/hrpf_pkg.sv
sv/hrpf_capture.sv
sv/hrpf_verdict.sv
sv/http_request_packet_filter.sv
test/tb_http_request_packet_filter.sv
